// ===== hdl/mat4_vector_transform_macros.svh =====
// Assertion macros used by the checker file of the vertex transform block
`ifndef MAT4_VECTOR_TRANSFORM_MACROS_SVH
`define MAT4_VECTOR_TRANSFORM_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define MVT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mvt_pkg.sv =====
// Shared types and constants of the vertex transform block
package mvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int N_DIM     = 4;
    localparam int N_ELEM    = N_DIM * N_DIM;
    localparam int IDX_W     = $clog2(N_ELEM);
    localparam int FULL_W    = 2 * DATA_W;
    localparam int PROD_W    = FULL_W - FRAC_BITS;
    localparam int SUM_W     = PROD_W + 3;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_VECTOR = 2'd1,
        OP_POINT  = 2'd2
    } t_op;

    typedef logic [N_ELEM-1:0][DATA_W-1:0] t_matrix;
    typedef logic [N_DIM-1:0][DATA_W-1:0]  t_vec;

    // products of one item, element order column*4+row
    typedef struct packed {
        logic                          valid;
        logic                          point;
        logic [N_ELEM-1:0]             corr;
        logic [N_ELEM-1:0][PROD_W-1:0] term;
    } t_prod;

endpackage

// ===== hdl/mvt_store.sv =====
// Matrix element store, cleared at reset, one element written per item
module mvt_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [mvt_pkg::IDX_W-1:0]  i_waddr,
    input  logic [mvt_pkg::DATA_W-1:0] i_wdata,
    output mvt_pkg::t_matrix           o_matrix
);

    mvt_pkg::t_matrix r_mem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_matrix = r_mem;

endmodule

// ===== hdl/mvt_prod.sv =====
// Sixteen element-by-component products, floored, with round-toward-zero carry bits
module mvt_prod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_point,
    input  mvt_pkg::t_matrix i_matrix,
    input  mvt_pkg::t_vec    i_vec,
    output mvt_pkg::t_prod   o_prod
);

    logic signed [mvt_pkg::FULL_W-1:0] full_prod [mvt_pkg::N_ELEM];
    logic [mvt_pkg::N_ELEM-1:0][mvt_pkg::PROD_W-1:0] n_term;
    logic [mvt_pkg::N_ELEM-1:0]                      n_corr;
    mvt_pkg::t_prod r_prod;

    for (genvar gc = 0; gc < mvt_pkg::N_DIM; gc++) begin : g_col
        for (genvar gr = 0; gr < mvt_pkg::N_DIM; gr++) begin : g_row
            localparam int IDX = gc * mvt_pkg::N_DIM + gr;

            assign full_prod[IDX] = $signed(i_matrix[IDX]) * $signed(i_vec[gc]);

            if (gc == mvt_pkg::N_DIM - 1) begin : g_trans
                // point mode: translation column enters the sum as is
                assign n_term[IDX] = i_point ?
                    {{(mvt_pkg::PROD_W - mvt_pkg::DATA_W){i_matrix[IDX][mvt_pkg::DATA_W-1]}},
                     i_matrix[IDX]} :
                    full_prod[IDX][mvt_pkg::FULL_W-1:mvt_pkg::FRAC_BITS];
                assign n_corr[IDX] = !i_point && full_prod[IDX][mvt_pkg::FULL_W-1] &&
                                     (|full_prod[IDX][mvt_pkg::FRAC_BITS-1:0]);
            end else begin : g_mul
                assign n_term[IDX] = full_prod[IDX][mvt_pkg::FULL_W-1:mvt_pkg::FRAC_BITS];
                assign n_corr[IDX] = full_prod[IDX][mvt_pkg::FULL_W-1] &&
                                     (|full_prod[IDX][mvt_pkg::FRAC_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else if (i_en) begin
            r_prod.valid <= i_valid;
        end
        if (i_en) begin
            r_prod.point <= i_point;
            r_prod.corr  <= n_corr;
            r_prod.term  <= n_term;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/mvt_sum.sv =====
// Row sums, saturation to 32 bits and the result register
module mvt_sum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mvt_pkg::t_prod i_prod,
    output logic           o_valid,
    output mvt_pkg::t_vec  o_data,
    output logic           o_sat
);

    localparam int EXT_W = mvt_pkg::SUM_W - mvt_pkg::PROD_W;

    logic [mvt_pkg::N_DIM-1:0][mvt_pkg::SUM_W-1:0]  row_sum;
    logic [mvt_pkg::N_DIM-1:0][mvt_pkg::DATA_W-1:0] row_val;
    logic [mvt_pkg::N_DIM-1:0]                      row_ovf;
    logic [mvt_pkg::N_DIM-1:0]                      row_use;
    mvt_pkg::t_vec n_data;
    logic          n_sat;

    logic          r_valid;
    mvt_pkg::t_vec r_data;
    logic          r_sat;

    for (genvar gr = 0; gr < mvt_pkg::N_DIM; gr++) begin : g_row
        logic [mvt_pkg::N_DIM-1:0][mvt_pkg::SUM_W-1:0] ext;
        logic [mvt_pkg::SUM_W-mvt_pkg::DATA_W:0]       hi;

        for (genvar gc = 0; gc < mvt_pkg::N_DIM; gc++) begin : g_col
            localparam int IDX = gc * mvt_pkg::N_DIM + gr;
            assign ext[gc] = {{EXT_W{i_prod.term[IDX][mvt_pkg::PROD_W-1]}}, i_prod.term[IDX]};
        end

        assign row_sum[gr] = ext[0] + ext[1] + ext[2] + ext[3]
            + {{(mvt_pkg::SUM_W-1){1'b0}}, i_prod.corr[gr]}
            + {{(mvt_pkg::SUM_W-1){1'b0}}, i_prod.corr[mvt_pkg::N_DIM + gr]}
            + {{(mvt_pkg::SUM_W-1){1'b0}}, i_prod.corr[2*mvt_pkg::N_DIM + gr]}
            + {{(mvt_pkg::SUM_W-1){1'b0}}, i_prod.corr[3*mvt_pkg::N_DIM + gr]};

        assign hi          = row_sum[gr][mvt_pkg::SUM_W-1:mvt_pkg::DATA_W-1];
        assign row_ovf[gr] = !((&hi) || !(|hi));
        assign row_val[gr] = !row_ovf[gr] ? row_sum[gr][mvt_pkg::DATA_W-1:0] :
                             row_sum[gr][mvt_pkg::SUM_W-1] ? mvt_pkg::Q_MIN : mvt_pkg::Q_MAX;

        // point mode: w row is dropped and reads zero
        if (gr == mvt_pkg::N_DIM - 1) begin : g_w
            assign row_use[gr] = !i_prod.point;
        end else begin : g_xyz
            assign row_use[gr] = 1'b1;
        end
        assign n_data[gr] = row_use[gr] ? row_val[gr] : '0;
    end

    assign n_sat = |(row_ovf & row_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_prod.valid;
        end
        if (i_en) begin
            r_data <= n_data;
            r_sat  <= n_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_sat   = r_sat;

endmodule

// ===== hdl/mat4_vector_transform.sv =====
// Top level of the 4x4 column-major matrix by vector transform block
//
// channel   dir  tvalid/tready                       tdata / tuser
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready   load, vector or point item
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready   transformed vector
//
// One item per cycle while no result waits on a low i_m_axis_tready; a result passes
// the input register, product register and result register. The sixteen 32x32
// multipliers set the period.
// Loads write the store as they leave the input register and give no result.
// Synchronous active-low reset clears the matrix store and all valid flags;
// o_s_axis_tready stays low while reset is held.
// When a result waits and i_m_axis_tready is low, the whole pipe holds and
// o_s_axis_tready drops; with the result register empty the input is ready outside reset.
module mat4_vector_transform (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [3:0] element_index, [35:4] element_value, [67:36] vec_x,
    // [99:68] vec_y, [131:100] vec_z, [163:132] vec_w, [167:164] zero
    input  logic [167:0] i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
    output logic [127:0] o_m_axis_tdata,
    // [0] saturated
    output logic [0:0]   o_m_axis_tuser
);

    logic                       en;
    logic                       s_accept;
    logic                       store_we;
    logic                       xform;
    logic                       point;
    mvt_pkg::t_matrix           matrix;
    mvt_pkg::t_prod             prod;
    mvt_pkg::t_vec              out_data;
    logic                       out_valid;
    logic                       out_sat;

    logic                       r_in_valid;
    mvt_pkg::t_op               r_op;
    logic [mvt_pkg::IDX_W-1:0]  r_idx;
    logic [mvt_pkg::DATA_W-1:0] r_val;
    mvt_pkg::t_vec              r_vec;

    assign en       = !out_valid || i_m_axis_tready;
    assign s_accept = i_s_axis_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (s_accept) begin
            r_op     <= mvt_pkg::t_op'(i_s_axis_tuser);
            r_idx    <= i_s_axis_tdata[3:0];
            r_val    <= i_s_axis_tdata[35:4];
            r_vec[0] <= i_s_axis_tdata[67:36];
            r_vec[1] <= i_s_axis_tdata[99:68];
            r_vec[2] <= i_s_axis_tdata[131:100];
            r_vec[3] <= i_s_axis_tdata[163:132];
        end
    end

    always_comb begin
        store_we = 1'b0;
        xform    = 1'b0;
        point    = 1'b0;
        case (r_op)
            mvt_pkg::OP_LOAD: begin
                store_we = r_in_valid && en;
            end
            mvt_pkg::OP_VECTOR: begin
                xform = r_in_valid;
            end
            mvt_pkg::OP_POINT: begin
                xform = r_in_valid;
                point = 1'b1;
            end
            default: begin
                xform = 1'b0;
            end
        endcase
    end

    mvt_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (store_we),
        .i_waddr  (r_idx),
        .i_wdata  (r_val),
        .o_matrix (matrix)
    );

    mvt_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (xform),
        .i_point  (point),
        .i_matrix (matrix),
        .i_vec    (r_vec),
        .o_prod   (prod)
    );

    mvt_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_prod  (prod),
        .o_valid (out_valid),
        .o_data  (out_data),
        .o_sat   (out_sat)
    );

    assign o_s_axis_tready = en && i_rst_n;
    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = out_data;
    assign o_m_axis_tuser  = out_sat;

endmodule

// ===== hdl/mvt_chk.sv =====
// Port-level checker of the vertex transform block and its bind
`include "mat4_vector_transform_macros.svh"

module mvt_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser
);

    logic stalled;
    logic any_clamp;

    assign stalled   = o_m_axis_tvalid && !i_m_axis_tready;
    assign any_clamp = o_m_axis_tdata[31:0] == 32'h7fff_ffff ||
                       o_m_axis_tdata[31:0] == 32'h8000_0000 ||
                       o_m_axis_tdata[63:32] == 32'h7fff_ffff ||
                       o_m_axis_tdata[63:32] == 32'h8000_0000 ||
                       o_m_axis_tdata[95:64] == 32'h7fff_ffff ||
                       o_m_axis_tdata[95:64] == 32'h8000_0000 ||
                       o_m_axis_tdata[127:96] == 32'h7fff_ffff ||
                       o_m_axis_tdata[127:96] == 32'h8000_0000;

    `MVT_ASSERT_NEXT(a_out_hold, stalled, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result item changed while stalled")
    `MVT_ASSERT_IMPL(a_ready_empty, !o_m_axis_tvalid, o_s_axis_tready, "input not ready with empty result register")
    `MVT_ASSERT_IMPL(a_stall_blocks, stalled, !o_s_axis_tready, "input taken while pipe is held")
    `MVT_ASSERT_IMPL(a_sat_value, o_m_axis_tvalid && o_m_axis_tuser[0], any_clamp, "saturated flag without a clamped component")

endmodule

bind mat4_vector_transform mvt_chk u_chk (.*);
